// File: rtl/inb_pkg.sv
// Package for the IQ impulse noise blanker: widths, codes, enum types and helpers.
// No dependencies; every other file of the block uses it.
package inb_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int WINDOW_LEN    = 128;
  localparam int WIN_AW        = $clog2(WINDOW_LEN);
  localparam int DELAY_LEN_DEF = 128;
  localparam int RAMP_LEN      = 4;

  localparam int GAIN_W     = 16;
  localparam int RAMP_REG_W = 64;
  localparam int POWER_W    = 2 * SAMPLE_BITS;
  localparam int SUM_W      = POWER_W + WIN_AW;
  localparam int KON_W      = 14;
  localparam int K_W        = KON_W + 2;
  localparam int PROD_W     = POWER_W + K_W;
  localparam int GPROD_W    = SAMPLE_BITS + GAIN_W + 1;
  localparam int PRE_W      = 8;
  localparam int CNT_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CNT_W-1:0] HOLD_OFF  = CNT_W'(1000);
  localparam logic [CNT_W-1:0] MAX_PULSE = CNT_W'(250);
  localparam logic [7:0]       PULSE_WIDTH_RST  = 8'd50;
  localparam logic [7:0]       DETECT_LEVEL_RST = 8'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLED,
    CFG_PULSE_WIDTH,
    CFG_DETECT_LEVEL,
    CFG_FADE_DOWN,
    CFG_FADE_UP
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_DOWN,
    PH_PRE,
    PH_MUTE,
    PH_UP
  } phase_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SUM,
    SEQ_MUL,
    SEQ_DEC
  } seq_e;

  // Trigger factor in Q6.8: 768 + round(38.4 * level), the divide by ten done by reciprocal.
  function automatic logic [KON_W-1:0] kon_from_level(input logic [7:0] level);
    logic [16:0] x;
    logic [32:0] p;
    x = 17'(level) * 17'd384 + 17'd5;
    p = 33'(x) * 33'd52429;
    return KON_W'(768) + KON_W'(p[32:19]);
  endfunction

  function automatic logic [7:0] width_from_setting(input logic [7:0] setting);
    return setting + 8'd1;
  endfunction

  function automatic logic [PRE_W-1:0] pre_len(input logic [7:0] width, input int unsigned limit);
    logic [PRE_W-1:0] p;
    p = PRE_W'({1'b0, width[7:1]}) + PRE_W'(5);
    if (32'(p) > limit) begin
      p = PRE_W'(limit);
    end
    return p;
  endfunction

  function automatic logic signed [GAIN_W-1:0] ramp_gain(input logic [RAMP_REG_W-1:0] r,
                                                         input logic [1:0] k);
    return $signed(r[{k, 4'b0000} +: GAIN_W]);
  endfunction

  // Arithmetic shift of a product that already holds its rounding half, then saturate to the sample width.
  function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
      input logic signed [GPROD_W-1:0] p);
    logic signed [GPROD_W-1:0] r;
    r = p >>> (GAIN_W - 1);
    if (r[GPROD_W-1:SAMPLE_BITS-1] == '0 || r[GPROD_W-1:SAMPLE_BITS-1] == '1) begin
      return r[SAMPLE_BITS-1:0];
    end else if (r[GPROD_W-1]) begin
      return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

endpackage

// File: rtl/inb_if.sv
// Valid/ready channel interfaces for the blanker's sample input and sample output.
// Depends on inb_pkg for the sample width.
interface inb_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [inb_pkg::SAMPLE_BITS-1:0] i_in;
  logic signed [inb_pkg::SAMPLE_BITS-1:0] q_in;

  modport source (output valid, output i_in, output q_in, input ready);
  modport sink   (input valid, input i_in, input q_in, output ready);
endinterface

interface inb_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [inb_pkg::SAMPLE_BITS-1:0] i_out;
  logic signed [inb_pkg::SAMPLE_BITS-1:0] q_out;

  modport source (output valid, output i_out, output q_out, input ready);
  modport sink   (input valid, input i_out, input q_out, output ready);
endinterface

// File: rtl/iq_impulse_noise_blanker_core.sv
// Top level of the IQ impulse noise blanker: power window, delay line and blanking control.
// Depends on inb_pkg and the channel interfaces in inb_if.sv.
//
// Each accepted request is one IQ sample and yields one output sample: the delayed, possibly
// blanked sample when enabled, the input sample itself when disabled. The accept cycle
// reads the power window and delay memories, then come a sum cycle, a multiply cycle and a
// decision cycle that loads the output register. The next request is accepted once that
// decision is made, so the block takes no new sample before the last one is through.
// A result waiting in the output register does not stop the next request from being
// accepted; it only holds that request at its decision cycle. No clearing pass follows
// reset: the window memory is tracked by a full flag and the delay memory by a fill count.
module iq_impulse_noise_blanker_core #(
  parameter int DELAY_LEN = inb_pkg::DELAY_LEN_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [inb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [inb_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  inb_in_if.sink                           in_i,
  inb_out_if.source                        out_o
);
  import inb_pkg::*;

  localparam int SB        = SAMPLE_BITS;
  localparam int AW        = $clog2(DELAY_LEN);
  localparam int FW        = $clog2(DELAY_LEN + 1);
  localparam int CW        = (AW + 1 > PRE_W + 1) ? AW + 1 : PRE_W + 1;
  localparam int PRE_LIMIT = DELAY_LEN / 2 - 1;
  localparam logic [7:0]       WIDTH_RST = width_from_setting(PULSE_WIDTH_RST);
  localparam logic [PRE_W-1:0] PRE_RST   = pre_len(WIDTH_RST, PRE_LIMIT);
  localparam logic [KON_W-1:0] KON_RST   = kon_from_level(DETECT_LEVEL_RST);

  // Configuration.
  logic                  en_q;
  logic [7:0]            width_q;
  logic [PRE_W-1:0]      pre_q;
  logic [KON_W-1:0]      kon_q;
  logic [RAMP_REG_W-1:0] fade_dn_q;
  logic [RAMP_REG_W-1:0] fade_up_q;

  // Control and blanking state.
  seq_e                  seq_q, seq_d;
  phase_e                phase_q, phase_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [POWER_W-1:0]    base_q, base_d;
  logic [SUM_W-1:0]      psum_q, psum_d;
  logic [WIN_AW-1:0]     widx_q;
  logic                  wfull_q, wfull_d;
  logic [AW-1:0]         wr_q, wr_inc;
  logic [FW-1:0]         fill_q, fill_d;
  logic                  ov_q, ov_d;

  // Per-request payload.
  logic signed [SB-1:0]      si_q, sq_q;
  logic [POWER_W-1:0]        sqi_q, sqq_q;
  logic [POWER_W-1:0]        win_old_q;
  logic [2*SB-1:0]           dly_rd_q;
  logic                      dly_vld_q;
  logic [POWER_W-1:0]        pwr_q;
  logic [SUM_W-1:0]          sum_q;
  logic signed [GPROD_W-1:0] gp_i_q, gp_q_q;
  logic signed [SB-1:0]      samp_i_q, samp_q_q;
  logic                      unity_q;
  logic [PROD_W-1:0]         on_prod_q, off_prod_q;
  logic signed [SB-1:0]      res_i_q, res_q_q;
  logic signed [SB-1:0]      oi_q, oq_q;

  logic [POWER_W-1:0] win_mem [WINDOW_LEN];
  logic [2*SB-1:0]    dly_mem [DELAY_LEN];

  logic in_ready, acc, out_ld, upd, win_we;

  // Accept-cycle addressing.
  logic [CW-1:0]            t_c, dly_c, rd_c;
  logic [AW-1:0]            rd_addr;
  logic                     rd_ok;
  logic [WIN_AW-1:0]        win_rd_addr;
  logic signed [2*SB-1:0]   sqi_full, sqq_full;

  // Datapath.
  logic [POWER_W-1:0]          pwr, avg;
  logic [SUM_W-1:0]            sum_now;
  logic signed [SB-1:0]        samp_i, samp_q;
  logic signed [GAIN_W-1:0]    gain;
  logic                        unity;
  logic signed [SB+GAIN_W-1:0] pm_i, pm_q;
  logic [K_W-1:0]              k_on;
  logic [KON_W-1:0]            k_off;
  logic [PROD_W-1:0]           on_prod, off_prod;
  logic                        det, mute_low;
  logic [CNT_W-1:0]            cnt_inc, cnt_mute;

  // Sequencer.
  always_comb begin
    seq_d = seq_q;
    case (seq_q)
      SEQ_IDLE: if (acc) seq_d = SEQ_SUM;
      SEQ_SUM:  seq_d = SEQ_MUL;
      SEQ_MUL:  seq_d = SEQ_DEC;
      SEQ_DEC:  if (out_ld) seq_d = SEQ_IDLE;
      default:  seq_d = SEQ_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (seq_q == SEQ_IDLE);
    acc      = in_i.valid && in_ready;
    out_ld   = (seq_q == SEQ_DEC) && (!ov_q || out_o.ready);
    upd      = out_ld && en_q;
    win_we   = (seq_q == SEQ_MUL) && en_q;
  end

  assign in_i.ready  = in_ready;
  assign out_o.valid = ov_q;
  assign out_o.i_out = oi_q;
  assign out_o.q_out = oq_q;

  // Delay line addressing: the read lags the write by the pre-mute length plus the ramp.
  always_comb begin
    wr_inc  = (wr_q == AW'(DELAY_LEN - 1)) ? '0 : wr_q + AW'(1);
    t_c     = CW'(wr_inc);
    dly_c   = CW'(pre_q) + CW'(RAMP_LEN);
    rd_c    = (t_c >= dly_c) ? t_c - dly_c : t_c + CW'(DELAY_LEN) - dly_c;
    rd_addr = rd_c[AW-1:0];
    fill_d  = ((FW'(wr_q) + FW'(1)) > fill_q) ? FW'(wr_q) + FW'(1) : fill_q;
    rd_ok   = CW'(rd_addr) < CW'(fill_d);
    win_rd_addr = widx_q + WIN_AW'(1);
    sqi_full = in_i.i_in * in_i.i_in;
    sqq_full = in_i.q_in * in_i.q_in;
  end

  always_ff @(posedge clk_i) begin
    if (acc && en_q) begin
      dly_mem[wr_q] <= {in_i.i_in, in_i.q_in};
    end
    if (acc) begin
      dly_rd_q <= dly_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (win_we) begin
      win_mem[widx_q] <= pwr_q;
    end
    if (acc) begin
      win_old_q <= win_mem[win_rd_addr];
    end
  end

  // Sum cycle: power, moving sum and the gain product for the delayed sample.
  always_comb begin
    pwr     = sqi_q + sqq_q;
    sum_now = psum_q + SUM_W'(pwr);
    samp_i  = dly_vld_q ? $signed(dly_rd_q[2*SB-1:SB]) : '0;
    samp_q  = dly_vld_q ? $signed(dly_rd_q[SB-1:0]) : '0;
    gain    = '0;
    unity   = 1'b0;
    case (phase_q)
      PH_DOWN: gain = ramp_gain(fade_dn_q, cnt_q[1:0]);
      PH_PRE:  gain = '0;
      PH_MUTE: gain = '0;
      PH_UP:   gain = ramp_gain(fade_up_q, cnt_q[1:0]);
      default: unity = 1'b1;
    endcase
    pm_i = samp_i * gain;
    pm_q = samp_q * gain;
  end

  // Multiply cycle: detection products and the window update.
  always_comb begin
    avg      = sum_q[SUM_W-1 -: POWER_W];
    k_on     = (cnt_q != '0) ? {kon_q, 2'b00} : {2'b00, kon_q};
    k_off    = kon_q + KON_W'(256);
    on_prod  = PROD_W'(avg) * PROD_W'(k_on);
    off_prod = PROD_W'(base_q) * PROD_W'(k_off);
    wfull_d  = wfull_q || (widx_q == WIN_AW'(WINDOW_LEN - 1));
    psum_d   = wfull_d ? sum_q - SUM_W'(win_old_q) : sum_q;
  end

  // Blanking state machine, advanced in the decision cycle.
  always_comb begin
    det      = PROD_W'({pwr_q, 8'h00}) > on_prod_q;
    mute_low = PROD_W'({pwr_q, 9'h000}) < off_prod_q;
    cnt_inc  = cnt_q + CNT_W'(1);
    cnt_mute = (cnt_q != '1) ? cnt_inc : cnt_q;
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    base_d   = base_q;
    case (phase_q)
      PH_WAIT: begin
        if (cnt_q != '0) cnt_d = cnt_q - CNT_W'(1);
        if (det) begin
          phase_d = PH_DOWN;
          cnt_d   = '0;
        end else begin
          base_d = avg;
        end
      end
      PH_DOWN: begin
        cnt_d = cnt_inc;
        if (cnt_inc >= CNT_W'(RAMP_LEN)) begin
          phase_d = PH_PRE;
          cnt_d   = '0;
        end
      end
      PH_PRE: begin
        cnt_d = cnt_inc;
        if (cnt_inc >= CNT_W'(pre_q)) begin
          phase_d = PH_MUTE;
          cnt_d   = '0;
        end
      end
      PH_MUTE: begin
        cnt_d = cnt_mute;
        if (cnt_mute >= CNT_W'(width_q) && (mute_low || cnt_mute >= MAX_PULSE)) begin
          phase_d = PH_UP;
          cnt_d   = '0;
        end
      end
      PH_UP: begin
        cnt_d = cnt_inc;
        if (cnt_inc >= CNT_W'(RAMP_LEN)) begin
          phase_d = PH_WAIT;
          cnt_d   = HOLD_OFF;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    if (out_ld) begin
      ov_d = 1'b1;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  // Configuration registers; pre-mute length and trigger factor are derived on write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q      <= 1'b0;
      width_q   <= WIDTH_RST;
      pre_q     <= PRE_RST;
      kon_q     <= KON_RST;
      fade_dn_q <= '0;
      fade_up_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENABLED: en_q <= cfg_data_i[0];
        CFG_PULSE_WIDTH: begin
          width_q <= width_from_setting(cfg_data_i[7:0]);
          pre_q   <= pre_len(width_from_setting(cfg_data_i[7:0]), PRE_LIMIT);
        end
        CFG_DETECT_LEVEL: kon_q <= kon_from_level(cfg_data_i[7:0]);
        CFG_FADE_DOWN: fade_dn_q <= cfg_data_i;
        CFG_FADE_UP: fade_up_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q   <= SEQ_IDLE;
      phase_q <= PH_WAIT;
      cnt_q   <= HOLD_OFF;
      base_q  <= '0;
      psum_q  <= '0;
      widx_q  <= '0;
      wfull_q <= 1'b0;
      wr_q    <= '0;
      fill_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      seq_q <= seq_d;
      ov_q  <= ov_d;
      if (acc) begin
        if (en_q) begin
          wr_q   <= wr_inc;
          fill_q <= fill_d;
        end else begin
          wr_q <= '0;
        end
      end
      if (win_we) begin
        psum_q  <= psum_d;
        wfull_q <= wfull_d;
        widx_q  <= widx_q + WIN_AW'(1);
      end
      if (upd) begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        base_q  <= base_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      si_q      <= in_i.i_in;
      sq_q      <= in_i.q_in;
      sqi_q     <= sqi_full;
      sqq_q     <= sqq_full;
      dly_vld_q <= rd_ok;
    end
    if (seq_q == SEQ_SUM) begin
      pwr_q    <= pwr;
      sum_q    <= sum_now;
      samp_i_q <= samp_i;
      samp_q_q <= samp_q;
      unity_q  <= unity;
      gp_i_q   <= $signed({pm_i[SB+GAIN_W-1], pm_i} + GPROD_W'(1 << (GAIN_W - 2)));
      gp_q_q   <= $signed({pm_q[SB+GAIN_W-1], pm_q} + GPROD_W'(1 << (GAIN_W - 2)));
    end
    if (seq_q == SEQ_MUL) begin
      on_prod_q  <= on_prod;
      off_prod_q <= off_prod;
      res_i_q    <= unity_q ? samp_i_q : round_sat(gp_i_q);
      res_q_q    <= unity_q ? samp_q_q : round_sat(gp_q_q);
    end
    if (out_ld) begin
      oi_q <= en_q ? res_i_q : si_q;
      oq_q <= en_q ? res_q_q : sq_q;
    end
  end

endmodule

// File: test/testbench.sv
// Testbench for iq_impulse_noise_blanker_core: drives IQ samples under random flow control
// and compares every output sample with a software copy of the blanking pipeline.
// Depends on inb_pkg, the channel interfaces in inb_if.sv and the RTL top level.

typedef struct {
  logic signed [inb_pkg::SAMPLE_BITS-1:0] i_val;
  logic signed [inb_pkg::SAMPLE_BITS-1:0] q_val;
} iq_t;

class blanker_mirror;
  bit              en;
  bit [7:0]        pw_set;
  bit [7:0]        lvl_set;
  bit [63:0]       ramp_dn;
  bit [63:0]       ramp_upw;
  longint unsigned pwr_win[inb_pkg::WINDOW_LEN];
  longint unsigned pwr_sum;
  int unsigned     win_pos;
  bit              win_full;
  iq_t             dly[128];
  int unsigned     dly_wr;
  inb_pkg::phase_e stage;
  int unsigned     stage_cnt;
  longint unsigned base_pwr;
  iq_t             due_iq[$];
  int unsigned     bad_count;

  function new();
    en = 1'b0;
    pw_set = 8'd50;
    lvl_set = 8'd50;
    ramp_dn = '0;
    ramp_upw = '0;
    foreach (pwr_win[k]) pwr_win[k] = 0;
    foreach (dly[k]) begin
      dly[k].i_val = '0;
      dly[k].q_val = '0;
    end
    pwr_sum = 0;
    win_pos = 0;
    win_full = 1'b0;
    dly_wr = 0;
    stage = inb_pkg::PH_WAIT;
    stage_cnt = 1000;
    base_pwr = 0;
    bad_count = 0;
  endfunction

  function void set_reg(inb_pkg::cfg_idx_e idx, logic [63:0] v);
    case (idx)
      inb_pkg::CFG_ENABLED:      en = v[0];
      inb_pkg::CFG_PULSE_WIDTH:  pw_set = v[7:0];
      inb_pkg::CFG_DETECT_LEVEL: lvl_set = v[7:0];
      inb_pkg::CFG_FADE_DOWN:    ramp_dn = v;
      inb_pkg::CFG_FADE_UP:      ramp_upw = v;
      default: ;
    endcase
  endfunction

  function logic signed [15:0] scale(logic signed [15:0] s, int g);
    longint p;
    p = (longint'(s) * longint'(g) + 16384) >>> 15;
    if (p > 32767) p = 32767;
    else if (p < -32768) p = -32768;
    return 16'(p);
  endfunction

  function void take_sample(iq_t s);
    bit [7:0]        width;
    int unsigned     pre;
    longint unsigned kon;
    longint unsigned k;
    longint unsigned pwr;
    longint unsigned sum_now;
    longint unsigned avg;
    longint signed   si;
    longint signed   sq;
    bit              zero_out;
    bit              ramped;
    int              g;
    int unsigned     rd;
    iq_t             res;
    if (!en) begin
      dly_wr = 0;
      due_iq.push_back(s);
      return;
    end
    width = pw_set + 8'd1;
    pre = width / 2 + 5;
    if (pre > 63) pre = 63;
    kon = 768 + (longint'(lvl_set) * 384 + 5) / 10;
    zero_out = 1'b0;
    ramped = 1'b0;
    g = 0;

    dly[dly_wr] = s;
    dly_wr = (dly_wr + 1) % 128;

    si = s.i_val;
    sq = s.q_val;
    pwr = longint'(si * si + sq * sq);
    sum_now = pwr_sum + pwr;
    pwr_win[win_pos] = pwr;
    win_pos = (win_pos + 1) % inb_pkg::WINDOW_LEN;
    if (win_pos == 0) win_full = 1'b1;
    pwr_sum = win_full ? sum_now - pwr_win[win_pos] : sum_now;
    avg = sum_now / inb_pkg::WINDOW_LEN;

    case (stage)
      inb_pkg::PH_WAIT: begin
        k = kon;
        if (stage_cnt != 0) begin
          stage_cnt--;
          k = k * 4;
        end
        if (pwr * 256 > avg * k) begin
          stage = inb_pkg::PH_DOWN;
          stage_cnt = 0;
        end else begin
          base_pwr = avg;
        end
      end
      inb_pkg::PH_DOWN: begin
        ramped = 1'b1;
        g = int'($signed(ramp_dn[16 * (stage_cnt % 4) +: 16]));
        stage_cnt++;
        if (stage_cnt >= inb_pkg::RAMP_LEN) begin
          stage = inb_pkg::PH_PRE;
          stage_cnt = 0;
        end
      end
      inb_pkg::PH_PRE: begin
        zero_out = 1'b1;
        stage_cnt++;
        if (stage_cnt >= pre) begin
          stage = inb_pkg::PH_MUTE;
          stage_cnt = 0;
        end
      end
      inb_pkg::PH_MUTE: begin
        zero_out = 1'b1;
        if (stage_cnt < 1023) stage_cnt++;
        if (stage_cnt >= width &&
            (pwr * 512 < base_pwr * (kon + 256) || stage_cnt >= 250)) begin
          stage = inb_pkg::PH_UP;
          stage_cnt = 0;
        end
      end
      inb_pkg::PH_UP: begin
        ramped = 1'b1;
        g = int'($signed(ramp_upw[16 * (stage_cnt % 4) +: 16]));
        stage_cnt++;
        if (stage_cnt >= inb_pkg::RAMP_LEN) begin
          stage = inb_pkg::PH_WAIT;
          stage_cnt = 1000;
        end
      end
      default: ;
    endcase

    rd = (dly_wr + 128 - ((pre + inb_pkg::RAMP_LEN) % 128)) % 128;
    res = dly[rd];
    if (zero_out) begin
      res.i_val = '0;
      res.q_val = '0;
    end else if (ramped) begin
      res.i_val = scale(res.i_val, g);
      res.q_val = scale(res.q_val, g);
    end
    due_iq.push_back(res);
  endfunction

  function void match_output(iq_t got);
    iq_t want;
    if (due_iq.size() == 0) begin
      $error("output sample with none expected: i_out %0d, q_out %0d", got.i_val, got.q_val);
      bad_count++;
      return;
    end
    want = due_iq.pop_front();
    if (got.i_val !== want.i_val) begin
      $error("i_out: expected %0d, got %0d", want.i_val, got.i_val);
      bad_count++;
    end
    if (got.q_val !== want.q_val) begin
      $error("q_out: expected %0d, got %0d", want.q_val, got.q_val);
      bad_count++;
    end
  endfunction
endclass

module testbench;
  import inb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 185;
  localparam int NUM_PHASES  = 9;
  localparam int LOUD_PHASE  = 4;
  localparam int LOUD_FIRST  = 60;
  localparam int LOUD_LAST   = 359;
  localparam int STALL_AFTER = 500;
  localparam int STALL_LEN   = 300;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  inb_in_if  in_if ();
  inb_out_if out_if ();

  blanker_mirror mirror;
  int unsigned   n_sent = 0;
  int unsigned   n_out = 0;
  iq_t           mon_in;
  iq_t           mon_out;

  iq_impulse_noise_blanker_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input int ph, input int idx);
    int unsigned                   r;
    logic signed [SAMPLE_BITS-1:0] v;
    r = $urandom_range(0, 99);
    if (ph == LOUD_PHASE && idx >= LOUD_FIRST && idx <= LOUD_LAST) begin
      v = SAMPLE_BITS'($urandom_range(20000, 32767));
      if (r < 50) v = -v;
      return v;
    end
    if (r < 3) return SAMPLE_BITS'($urandom);
    if (r == 3) return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    if (r == 4) return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    return SAMPLE_BITS'($urandom_range(0, 400)) - SAMPLE_BITS'(200);
  endfunction

  task automatic write_cfg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
  endtask

  task automatic configure(input int ph);
    case (ph)
      0: write_cfg(CFG_ENABLED, CFG_DATA_W'(0));
      1: begin
        write_cfg(CFG_ENABLED, CFG_DATA_W'(1));
        write_cfg(CFG_FADE_DOWN, 64'h1000_2000_4000_6000);
        write_cfg(CFG_FADE_UP, 64'h6000_4000_2000_1000);
      end
      2: begin
        write_cfg(CFG_PULSE_WIDTH, CFG_DATA_W'(0));
        write_cfg(CFG_DETECT_LEVEL, CFG_DATA_W'(0));
        write_cfg(CFG_FADE_DOWN, 64'h8000_7fff_c000_0001);
        write_cfg(CFG_FADE_UP, 64'h0000_8000_ffff_7fff);
      end
      3: begin
        write_cfg(CFG_PULSE_WIDTH, CFG_DATA_W'(255));
        write_cfg(CFG_DETECT_LEVEL, CFG_DATA_W'(255));
      end
      4: begin
        write_cfg(CFG_PULSE_WIDTH, CFG_DATA_W'(100));
        write_cfg(CFG_DETECT_LEVEL, CFG_DATA_W'(10));
      end
      5: write_cfg(CFG_ENABLED, CFG_DATA_W'(0));
      6: begin
        write_cfg(CFG_ENABLED, CFG_DATA_W'(1));
        write_cfg(CFG_PULSE_WIDTH, CFG_DATA_W'(20));
        write_cfg(CFG_DETECT_LEVEL, CFG_DATA_W'(100));
        write_cfg(CFG_FADE_DOWN, CFG_DATA_W'(0));
        write_cfg(CFG_FADE_UP, CFG_DATA_W'(0));
      end
      default: begin
        write_cfg(CFG_ENABLED, CFG_DATA_W'(1));
        write_cfg(CFG_PULSE_WIDTH, CFG_DATA_W'($urandom_range(0, 255)));
        write_cfg(CFG_DETECT_LEVEL, CFG_DATA_W'($urandom_range(0, 255)));
        write_cfg(CFG_FADE_DOWN, {$urandom, $urandom});
        write_cfg(CFG_FADE_UP, {$urandom, $urandom});
      end
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_items(input int count, input int ph);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && sent < count; b++) begin
        in_if.valid <= 1'b1;
        in_if.i_in  <= pick_sample(ph, sent);
        in_if.q_in  <= pick_sample(ph, sent);
        do @(posedge clk_i); while (!in_if.ready);
        sent++;
        n_sent++;
      end
      gap = $urandom_range(0, 6);
      if (gap > 0 && sent < count) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_if.valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (n_out != n_sent) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        mirror.set_reg(cfg_idx_e'(cfg_idx_i), cfg_data_i);
      end
      if (in_if.valid && in_if.ready) begin
        mon_in.i_val = in_if.i_in;
        mon_in.q_val = in_if.q_in;
        mirror.take_sample(mon_in);
      end
      if (out_if.valid && out_if.ready) begin
        mon_out.i_val = out_if.i_out;
        mon_out.q_val = out_if.q_out;
        mirror.match_output(mon_out);
        n_out++;
      end
    end
  end

  initial begin : receiver
    int unsigned rcnt;
    int unsigned hold;
    bit          long_done;
    rcnt = 0;
    hold = 0;
    long_done = 1'b0;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      rcnt++;
      if (!long_done && n_sent >= STALL_AFTER) begin
        long_done = 1'b1;
        hold = STALL_LEN;
      end
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= (rcnt % 9 < 6) || ($urandom_range(0, 1) == 1);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $error("cycle limit of %0d reached", CYCLE_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin : main
    mirror = new();
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    in_if.valid = 1'b0;
    in_if.i_in  = '0;
    in_if.q_in  = '0;
    rst_ni      = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      configure(ph);
      send_items((ph == LOUD_PHASE) ? 2 * PHASE_ITEMS : PHASE_ITEMS, ph);
      wait_drain();
    end
    repeat (5) @(posedge clk_i);
    if (mirror.bad_count == 0 && mirror.due_iq.size() == 0 && n_out == n_sent) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/inb_pkg.sv
rtl/inb_if.sv
rtl/iq_impulse_noise_blanker_core.sv
test/testbench.sv
